// ===== rtl/core/smcp_pkg.sv =====
// smcp_pkg: types, codes and constants of the serial motor command parser
// no dependencies; imported by the core and by its port checker
`default_nettype none

package smcp_pkg;

    // longest line in bytes; a line closes as soon as this many are stored
    localparam int LINE_MAX = 31;
    localparam int POS_W    = $clog2(LINE_MAX + 1);

    localparam logic [7:0] NL_BYTE    = 8'd10;
    localparam logic [7:0] NUL_BYTE   = 8'd0;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CMD_DRIVE  = 8'h63;  // 'c'
    localparam logic [7:0] CMD_SENSE  = 8'h69;  // 'i'

    localparam logic [7:0] GAIN_RESET    = 8'd13;
    localparam logic [7:0] NEUTRAL_RESET = 8'd90;

    // x / 10 == (x * RECIP_DIV10) >> RECIP_SHIFT, exact for x below 2**24
    localparam int          PROD_W      = 24;
    localparam int          RECIP_SHIFT = 27;
    localparam logic [PROD_W-1:0] RECIP_DIV10 = PROD_W'((64'd1 << RECIP_SHIFT) / 10 + 1);

    typedef enum logic [0:0] {
        CFG_GAIN    = 1'b0,
        CFG_NEUTRAL = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BAD    = 2'd1,
        STAT_SENSOR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        VERDICT_PENDING = 2'd0,
        VERDICT_GOOD    = 2'd1,
        VERDICT_BAD     = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       right_sensor;
        logic       left_sensor;
    } rx_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] right_drive;
        logic signed [15:0] left_drive;
        logic               right_level;
        logic               left_level;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/serial_motor_command_parser_core.sv =====
// serial_motor_command_parser_core: byte-wise command line parser with drive scaling
// depends on smcp_pkg
`default_nettype none

// Takes one received byte per transaction on rx and may give one result per
// line on res. Bytes collect into a line that ends at a newline or once
// LINE_MAX bytes are stored. A 'c' line gives either accepted drive values
// (status ok) or a bad-command result; an 'i' line reports the two sensor
// levels seen with its closing byte; other lines and empty lines give nothing.
// A new byte can be taken in every clock cycle while rx is not stalled. Line
// parsing is done in the cycle a byte is taken; a closed line then runs
// through four registered stages (capture, gain multiply, divide by ten as a
// reciprocal multiply, neutral offset into the output register). The stages
// collapse bubbles, so rx only stalls once all four stages hold results that
// res has not taken. Configuration writes are taken in any cycle (cfg_ready
// stays high) and must only be made while no line result is still in flight.
module serial_motor_command_parser_core
    import smcp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     rx_valid,
    output logic          rx_ready,
    input  wire rx_item_t rx_item,
    output logic          res_valid,
    input  wire logic     res_ready,
    output result_t       res_item,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire cfg_idx_t cfg_index,
    input  wire logic [7:0] cfg_data
);

    // per-line parse context
    typedef struct packed {
        logic        neg;
        logic [15:0] acc;
        logic        has_dig;
        logic [1:0]  fcnt;
        logic [15:0] first;
        logic [15:0] second;
        verdict_t    verdict;
    } parse_t;

    // result tag carried down the pipeline
    typedef struct packed {
        status_t     status;
        logic [15:0] r_raw;
        logic [15:0] l_raw;
        logic        scale_r;
        logic        scale_l;
        logic        r_lvl;
        logic        l_lvl;
    } tag_t;

    localparam parse_t PARSE_CLEAR = '{
        neg: 1'b0, acc: '0, has_dig: 1'b0, fcnt: '0,
        first: '0, second: '0, verdict: VERDICT_PENDING
    };

    // one speed-text byte into the parse context
    function automatic parse_t feed(input parse_t p, input logic [7:0] c);
        parse_t      q;
        logic [15:0] val;
        logic [1:0]  fc;
        begin
            q   = p;
            val = '0;
            fc  = '0;
            if (p.verdict == VERDICT_PENDING)
            begin
                if (c == NUL_BYTE || c == CHAR_COMMA)
                begin
                    if (!p.has_dig)
                    begin
                        q.verdict = VERDICT_BAD;
                    end
                    else
                    begin
                        val = p.neg ? 16'(16'd0 - p.acc) : p.acc;
                        if (p.fcnt == 2'd0)
                            q.first = val;
                        else
                            q.second = val;
                        fc        = 2'(p.fcnt + 2'd1);
                        q.fcnt    = fc;
                        q.neg     = 1'b0;
                        q.acc     = '0;
                        q.has_dig = 1'b0;
                        if (fc >= 2'd2)
                            q.verdict = VERDICT_GOOD;
                        else if (c == NUL_BYTE)
                            q.verdict = VERDICT_BAD;
                    end
                end
                else if (c == CHAR_MINUS)
                begin
                    q.neg = 1'b1;
                end
                else if (c >= CHAR_ZERO && c <= CHAR_NINE)
                begin
                    // acc * 10 + digit, wrapping at 16 bits
                    q.acc     = 16'({p.acc, 3'b000} + {p.acc, 1'b0} + {12'd0, c[3:0]});
                    q.has_dig = 1'b1;
                end
                else
                begin
                    q.verdict = VERDICT_BAD;
                end
            end
            return q;
        end
    endfunction

    // configuration registers
    logic [7:0] gain_reg;
    logic [7:0] neutral_reg;

    // line state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       cmd_reg, cmd_next;
    parse_t           parse_reg, parse_next;

    // result pipeline
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    tag_t                    s1_reg, s2_reg, s3_reg;
    logic [PROD_W-1:0]       s2_prod_r_reg, s2_prod_l_reg;
    logic [15:0]             s3_quot_r_reg, s3_quot_l_reg;
    result_t                 out_reg, out_next;
    tag_t                    s1_next;
    logic                    s1_load;

    logic ready1, ready2, ready3, ready4;
    logic rx_accept;

    // combinational parse intermediates
    logic [POS_W-1:0] pos_f;
    logic [7:0]       cmd_f;
    parse_t           parse_f, parse_fin;
    logic             line_end;
    logic             good;

    // multiply / divide intermediates
    logic [15:0]                l_mag;
    logic [2*PROD_W-1:0]        recip_r, recip_l;
    logic [15:0]                right_sum, left_sum;

    // ready chain: a stage takes new data when empty or when it moves on
    assign ready4    = !out_valid_reg || res_ready;
    assign ready3    = !s3_valid_reg || ready4;
    assign ready2    = !s2_valid_reg || ready3;
    assign ready1    = !s1_valid_reg || ready2;
    assign rx_ready  = ready1;
    assign rx_accept = rx_valid && rx_ready;
    assign cfg_ready = 1'b1;

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

    // configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= GAIN_RESET;
            neutral_reg <= NEUTRAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GAIN:    gain_reg    <= cfg_data;
                CFG_NEUTRAL: neutral_reg <= cfg_data;
                default:     gain_reg    <= gain_reg;
            endcase
        end
    end

    // byte parse and line close
    always_comb
    begin
        pos_f     = pos_reg;
        cmd_f     = cmd_reg;
        parse_f   = parse_reg;
        parse_fin = parse_reg;
        line_end  = 1'b0;
        good      = 1'b0;
        s1_next   = '0;
        s1_load   = 1'b0;

        if (rx_item.rx_byte == NL_BYTE)
        begin
            // newline is not stored; close with the current context
            line_end = 1'b1;
        end
        else
        begin
            if (pos_reg == '0)
                cmd_f = rx_item.rx_byte;
            else if (pos_reg >= POS_W'(2))
                parse_f = feed(parse_reg, rx_item.rx_byte);
            pos_f    = POS_W'(pos_reg + POS_W'(1));
            line_end = (pos_f >= POS_W'(LINE_MAX));
        end

        // closing a drive line: flush the last field, or fail a too-short line
        if (pos_f >= POS_W'(2))
        begin
            parse_fin = feed(parse_f, NUL_BYTE);
        end
        else
        begin
            parse_fin         = parse_f;
            parse_fin.verdict = VERDICT_BAD;
        end
        good = (parse_fin.verdict == VERDICT_GOOD);

        if (cmd_f == CMD_SENSE)
        begin
            s1_next.status = STAT_SENSOR;
            s1_next.r_lvl  = rx_item.right_sensor;
            s1_next.l_lvl  = rx_item.left_sensor;
        end
        else if (good)
        begin
            s1_next.status  = STAT_OK;
            s1_next.r_raw   = parse_fin.first;
            s1_next.l_raw   = parse_fin.second;
            // forward right and reverse left get the gain
            s1_next.scale_r = !parse_fin.first[15] && (parse_fin.first != '0);
            s1_next.scale_l = parse_fin.second[15];
        end
        else
        begin
            s1_next.status = STAT_BAD;
        end

        s1_load = rx_accept && line_end && (pos_f != '0)
                  && (cmd_f == CMD_SENSE || cmd_f == CMD_DRIVE);

        if (rx_accept && line_end)
        begin
            pos_next   = '0;
            cmd_next   = '0;
            parse_next = PARSE_CLEAR;
        end
        else if (rx_accept)
        begin
            pos_next   = pos_f;
            cmd_next   = cmd_f;
            parse_next = parse_f;
        end
        else
        begin
            pos_next   = pos_reg;
            cmd_next   = cmd_reg;
            parse_next = parse_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            cmd_reg   <= '0;
            parse_reg <= PARSE_CLEAR;
        end
        else
        begin
            pos_reg   <= pos_next;
            cmd_reg   <= cmd_next;
            parse_reg <= parse_next;
        end
    end

    // reverse-left magnitude; 0x8000 comes out right as unsigned
    assign l_mag   = 16'(16'd0 - s1_reg.l_raw);
    assign recip_r = s2_prod_r_reg * RECIP_DIV10;
    assign recip_l = s2_prod_l_reg * RECIP_DIV10;

    // neutral offset, wrapping at 16 bits
    always_comb
    begin
        right_sum = s3_reg.scale_r ? 16'({8'd0, neutral_reg} + s3_quot_r_reg)
                                   : 16'({8'd0, neutral_reg} + s3_reg.r_raw);
        left_sum  = s3_reg.scale_l ? 16'({8'd0, neutral_reg} + s3_quot_l_reg)
                                   : 16'({8'd0, neutral_reg} - s3_reg.l_raw);
        out_next             = '0;
        out_next.status      = s3_reg.status;
        if (s3_reg.status == STAT_OK)
        begin
            out_next.right_drive = right_sum;
            out_next.left_drive  = left_sum;
        end
        if (s3_reg.status == STAT_SENSOR)
        begin
            out_next.right_level = s3_reg.r_lvl;
            out_next.left_level  = s3_reg.l_lvl;
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                s1_valid_reg <= s1_load;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
            if (ready3)
                s3_valid_reg <= s2_valid_reg;
            if (ready4)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (ready1 && s1_load)
            s1_reg <= s1_next;
        if (ready2 && s1_valid_reg)
        begin
            s2_reg        <= s1_reg;
            s2_prod_r_reg <= PROD_W'(s1_reg.r_raw) * PROD_W'(gain_reg);
            s2_prod_l_reg <= PROD_W'(l_mag) * PROD_W'(gain_reg);
        end
        if (ready3 && s2_valid_reg)
        begin
            s3_reg        <= s2_reg;
            s3_quot_r_reg <= recip_r[RECIP_SHIFT +: 16];
            s3_quot_l_reg <= recip_l[RECIP_SHIFT +: 16];
        end
        if (ready4 && s3_valid_reg)
            out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/smcp_port_checker.sv =====
// smcp_port_checker: port-level checks of the serial motor command parser core
// depends on smcp_pkg; bound to serial_motor_command_parser_core below
`default_nettype none

module smcp_port_checker
    import smcp_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     res_valid,
    input wire logic     res_ready,
    input wire result_t  res_item,
    input wire logic     cfg_ready
);

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    // drive values only on accepted speed lines
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.status != STAT_OK |->
            res_item.right_drive == 16'sd0 && res_item.left_drive == 16'sd0)
        else $error("drive values on a non-speed result");

    // sensor levels only on sensor reports
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.status != STAT_SENSOR |->
            !res_item.right_level && !res_item.left_level)
        else $error("sensor levels on a non-sensor result");

    // configuration writes never stall
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind serial_motor_command_parser_core smcp_port_checker u_smcp_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
